// File: hw/rtl/page_frame_pool_manager_defines.svh
// Assertion macros for the page frame pool manager.
`ifndef PAGE_FRAME_POOL_MANAGER_DEFINES_SVH
`define PAGE_FRAME_POOL_MANAGER_DEFINES_SVH
`ifndef SYNTH
`define PFPM_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PFPM_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define PFPM_ASSERT_IMPL(label, clk, rst_n, a, c)
`define PFPM_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: hw/rtl/pfpm_pkg.sv
// Shared types and constants for the page frame pool manager.
package pfpm_pkg;
    localparam int FRAMES = 16;
    localparam int PAGE_ID_BITS = 20;
    localparam int PIN_BITS = 8;
    localparam int FB = $clog2(FRAMES);
    localparam int CB = $clog2(FRAMES + 1);

    localparam logic [2:0] REQ_FETCH = 3'd0;
    localparam logic [2:0] REQ_NEW = 3'd1;
    localparam logic [2:0] REQ_DELETE = 3'd2;
    localparam logic [2:0] REQ_UNPIN = 3'd3;
    localparam logic [2:0] REQ_FLUSH = 3'd4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_RES = 3'd1;
    localparam logic [2:0] ST_PINNED = 3'd2;
    localparam logic [2:0] ST_UNPINNED = 3'd3;
    localparam logic [2:0] ST_NO_FRAME = 3'd4;
    localparam logic [2:0] ST_PIN_OVF = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_DECIDE, S_LRU, S_DONE
    } t_state;

    // one operation on the LRU list
    typedef struct packed {
        logic          ins;
        logic          rem;
        logic [FB-1:0] frame;
    } t_lru_op;
endpackage

// File: hw/rtl/page_frame_pool_manager.sv
// Top level of the page frame pool manager.
// A request passes through a scan of all frames, a decide step (with an extra step when an
// LRU victim's metadata is read), the LRU pass and a finish step before o_valid goes high.
// One request at a time: busy drops in the o_valid cycle, so the next request can be taken
// there. The receiver cannot stall.
// Reset (synchronous, active low) empties the pool and refills the free queue.
`include "page_frame_pool_manager_defines.svh"
module page_frame_pool_manager import pfpm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              i_req_type,
    input  logic [PAGE_ID_BITS-1:0] i_page_id,
    input  logic                    i_mark_dirty,
    output logic                    o_valid,
    output logic [2:0]              o_status,
    output logic [3:0]              o_frame,
    output logic                    o_write_valid,
    output logic [PAGE_ID_BITS-1:0] o_write_page_id,
    output logic [3:0]              o_write_frame,
    output logic                    o_load_page,
    output logic                    o_dealloc_page
);
    t_state r_state, n_state;
    logic [2:0] r_req;
    logic [PAGE_ID_BITS-1:0] r_pid;
    logic r_md;
    logic [CB-1:0] r_scan;      // frame address being issued
    logic r_hit;
    logic [FB-1:0] r_hf;
    logic [PIN_BITS-1:0] r_hpins;
    logic r_hdirty;
    logic [PAGE_ID_BITS-1:0] r_htag;
    logic [CB-1:0] r_cnt_q;     // address whose read data is on the bus
    logic r_qv;

    // free queue in flops-addressed memory
    logic [FB-1:0] fq [FRAMES];
    logic [FB-1:0] r_fhead;
    logic [CB-1:0] r_fcount;
    logic [FB-1:0] r_fq_q;
    logic [FRAMES-1:0] r_fq_init;  // entry not yet written since reset

    // metadata port
    logic [FB-1:0] m_raddr;
    logic [PAGE_ID_BITS-1:0] m_tag;
    logic [PIN_BITS-1:0] m_pins;
    logic m_valid, m_dirty, m_we, m_wvalid, m_wdirty;
    logic [FB-1:0] m_waddr;
    logic [PAGE_ID_BITS-1:0] m_wtag;
    logic [PIN_BITS-1:0] m_wpins;

    logic lru_go, lru_busy;
    t_lru_op lru_op;
    logic [FB-1:0] lru_old;
    logic [CB-1:0] lru_cnt;

    // result registers
    logic [2:0] r_st;
    logic [FB-1:0] r_fr, r_wf;
    logic r_wv, r_ld, r_dl, r_out;
    logic [PAGE_ID_BITS-1:0] r_wp;
    logic r_victim;  // need to read victim metadata

    logic d_need_victim;
    logic dec_fire;

    pfpm_meta u_meta (
        .i_clk, .i_rst_n, .i_raddr(m_raddr), .o_tag(m_tag), .o_pins(m_pins),
        .o_valid(m_valid), .o_dirty(m_dirty), .i_we(m_we), .i_waddr(m_waddr),
        .i_tag(m_wtag), .i_pins(m_wpins), .i_valid(m_wvalid), .i_dirty(m_wdirty)
    );
    pfpm_lru u_lru (
        .i_clk, .i_rst_n, .i_go(lru_go), .i_op(lru_op), .o_busy(lru_busy),
        .o_oldest(lru_old), .o_count(lru_cnt)
    );

    assign busy = (r_state != S_IDLE);
    // present the victim address while r_victim is still low so its data is
    // on the bus once r_victim is set
    assign m_raddr = (r_state == S_DECIDE && d_need_victim) ? lru_old : r_scan[FB-1:0];

    always_ff @(posedge i_clk) begin
        r_fq_q <= r_fq_init[r_fhead] ? r_fhead : fq[r_fhead];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (start) n_state = S_LOOK;
            S_LOOK:   if (r_qv && r_cnt_q == CB'(FRAMES - 1)) n_state = S_DECIDE;
            S_DECIDE: if (dec_fire) n_state = S_LRU;
            S_LRU:    if (!lru_busy) n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // decision, evaluated in S_DECIDE
    always_comb begin
        d_need_victim = (r_req == REQ_FETCH || r_req == REQ_NEW) && !r_hit
                        && r_fcount == '0 && lru_cnt != '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out <= 1'b0;
            r_fhead <= '0;
            r_fcount <= CB'(FRAMES);
            r_fq_init <= '1;
            r_victim <= 1'b0;
            r_qv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out <= (r_state == S_DONE);
            case (r_state)
                S_IDLE: if (start) begin
                    r_req <= i_req_type;
                    r_pid <= i_page_id;
                    r_md <= i_mark_dirty;
                    r_scan <= '0;
                    r_hit <= 1'b0;
                    r_qv <= 1'b0;
                    r_victim <= 1'b0;
                    r_st <= ST_NOT_RES;
                    r_fr <= '0; r_wf <= '0; r_wp <= '0;
                    r_wv <= 1'b0; r_ld <= 1'b0; r_dl <= 1'b0;
                end
                S_LOOK: begin
                    if (r_scan < CB'(FRAMES)) r_scan <= r_scan + 1'b1;
                    r_qv <= r_scan < CB'(FRAMES);
                    r_cnt_q <= r_scan;
                    if (r_qv && m_valid && m_tag == r_pid && !r_hit) begin
                        r_hit <= 1'b1;
                        r_hf <= r_cnt_q[FB-1:0];
                        r_hpins <= m_pins;
                        r_hdirty <= m_dirty;
                        r_htag <= m_tag;
                    end
                    if (r_qv && r_cnt_q == CB'(FRAMES - 1)) r_victim <= 1'b0;
                end
                S_DECIDE: begin
                    if (d_need_victim && !r_victim) begin
                        r_victim <= 1'b1;   // wait for the victim read
                    end else begin
                        r_victim <= 1'b0;
                        if (r_req > REQ_FLUSH) r_st <= ST_NOT_RES;
                        else if (r_req == REQ_FETCH || r_req == REQ_NEW) begin
                            if (r_hit) begin
                                if (r_req == REQ_NEW) r_st <= ST_PINNED;
                                else if (&r_hpins) r_st <= ST_PIN_OVF;
                                else begin r_st <= ST_OK; r_fr <= r_hf; end
                            end else if (r_fcount != '0) begin
                                r_st <= ST_OK; r_fr <= r_fq_q;
                                r_ld <= (r_req == REQ_FETCH);
                                r_fhead <= r_fhead + 1'b1;
                                r_fcount <= r_fcount - 1'b1;
                            end else if (r_victim) begin
                                r_st <= ST_OK; r_fr <= lru_old;
                                r_ld <= (r_req == REQ_FETCH);
                                r_wv <= m_dirty;
                                r_wp <= m_dirty ? m_tag : '0;
                                r_wf <= m_dirty ? lru_old : '0;
                            end else r_st <= ST_NO_FRAME;
                        end else if (r_req == REQ_DELETE) begin
                            if (!r_hit) begin r_st <= ST_OK; r_dl <= 1'b1; end
                            else if (r_hpins != '0) r_st <= ST_PINNED;
                            else begin
                                r_st <= ST_OK; r_fr <= r_hf; r_dl <= 1'b1;
                                fq[r_fhead + r_fcount[FB-1:0]] <= r_hf;
                                r_fq_init[r_fhead + r_fcount[FB-1:0]] <= 1'b0;
                                r_fcount <= r_fcount + 1'b1;
                            end
                        end else if (!r_hit) r_st <= ST_NOT_RES;
                        else if (r_req == REQ_UNPIN) begin
                            if (r_hpins == '0) r_st <= ST_UNPINNED;
                            else begin r_st <= ST_OK; r_fr <= r_hf; end
                        end else begin
                            r_st <= ST_OK; r_fr <= r_hf;
                            r_wv <= 1'b1; r_wp <= r_htag; r_wf <= r_hf;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // metadata write and LRU op, issued on the final S_DECIDE cycle
    assign dec_fire = (r_state == S_DECIDE) && !(d_need_victim && !r_victim);
    always_comb begin
        m_we = 1'b0; m_waddr = r_hf; m_wtag = r_htag; m_wpins = r_hpins;
        m_wvalid = 1'b1; m_wdirty = r_hdirty;
        lru_go = 1'b0; lru_op = '{ins: 1'b0, rem: 1'b0, frame: r_hf};
        if (dec_fire && r_req <= REQ_FLUSH) begin
            if (r_req == REQ_FETCH || r_req == REQ_NEW) begin
                if (r_hit) begin
                    if (r_req == REQ_FETCH && !(&r_hpins)) begin
                        m_we = 1'b1; m_wpins = r_hpins + 1'b1;
                        lru_go = 1'b1; lru_op.rem = 1'b1;
                    end
                end else if (r_fcount != '0 || r_victim) begin
                    m_we = 1'b1;
                    m_waddr = (r_fcount != '0) ? r_fq_q : lru_old;
                    m_wtag = r_pid; m_wpins = PIN_BITS'(1); m_wdirty = 1'b0;
                    if (r_fcount == '0) begin
                        lru_go = 1'b1; lru_op.rem = 1'b1; lru_op.frame = lru_old;
                    end
                end
            end else if (r_req == REQ_DELETE) begin
                if (r_hit && r_hpins == '0) begin
                    m_we = 1'b1; m_wvalid = 1'b0; m_wdirty = 1'b0; m_wpins = '0;
                    lru_go = 1'b1; lru_op.rem = 1'b1;
                end
            end else if (r_hit && r_req == REQ_UNPIN) begin
                if (r_hpins != '0) begin
                    m_we = 1'b1; m_wpins = r_hpins - 1'b1;
                    m_wdirty = r_hdirty | r_md;
                    if (r_hpins == PIN_BITS'(1)) begin
                        lru_go = 1'b1; lru_op.ins = 1'b1;
                    end
                end
            end else if (r_hit) begin
                m_we = 1'b1; m_wdirty = 1'b0;
            end
        end
    end

    assign o_valid = r_out;
    assign o_status = r_st;
    assign o_frame = 4'(r_fr);
    assign o_write_valid = r_wv;
    assign o_write_page_id = r_wp;
    assign o_write_frame = 4'(r_wf);
    assign o_load_page = r_ld;
    assign o_dealloc_page = r_dl;

    // checks
    `PFPM_ASSERT_IMPL(a_out_idle, i_clk, i_rst_n, r_out, r_state == S_IDLE)
    `PFPM_ASSERT_IMPL(a_fcount_max, i_clk, i_rst_n, 1'b1, r_fcount <= CB'(FRAMES))
    `PFPM_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
endmodule

// File: hw/rtl/pfpm_lru.sv
// LRU order of unpinned frames: a memory with a shifting pass that removes or appends a frame.
module pfpm_lru import pfpm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  t_lru_op       i_op,
    output logic          o_busy,
    output logic [FB-1:0] o_oldest,
    output logic [CB-1:0] o_count
);
    logic [FB-1:0] mem [FRAMES];
    logic [CB-1:0] r_count, r_rd, r_wr;
    logic [FB-1:0] r_frame;
    logic          r_run, r_ins, r_found;
    logic [FB-1:0] r_q;
    logic          r_qv;

    assign o_count = r_count;
    assign o_busy = r_run | i_go;

    // head entry is read whenever idle
    always_ff @(posedge i_clk) begin
        if (r_run) r_q <= mem[r_rd[FB-1:0]];
        else       r_q <= mem[0];
        if (r_qv && r_q != r_frame) mem[r_wr[FB-1:0]] <= r_q;
        else if (r_run && !r_qv && r_rd == r_count && r_ins && !r_found
                 && r_wr < CB'(FRAMES)) mem[r_wr[FB-1:0]] <= r_frame;
    end
    assign o_oldest = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_run <= 1'b0;
            r_qv <= 1'b0;
        end else if (i_go) begin
            r_run <= 1'b1;
            r_rd <= '0;
            r_wr <= '0;
            r_frame <= i_op.frame;
            r_ins <= i_op.ins;
            r_found <= 1'b0;
            r_qv <= 1'b0;
        end else if (r_run) begin
            // pipeline: read at r_rd, compact-write the previous read
            if (r_qv) begin
                if (r_q != r_frame) r_wr <= r_wr + 1'b1;
                else r_found <= 1'b1;
            end
            if (r_rd < r_count) begin
                r_rd <= r_rd + 1'b1;
                r_qv <= 1'b1;
            end else if (r_qv) begin
                r_qv <= 1'b0;
            end else begin
                r_run <= 1'b0;
                if (r_ins && !r_found && r_wr < CB'(FRAMES)) r_count <= r_wr + 1'b1;
                else if (r_ins) r_count <= r_count;
                else r_count <= r_wr;
            end
        end
    end
endmodule

// File: hw/rtl/pfpm_meta.sv
// Frame metadata store: tag, valid, pins and dirty per frame.
module pfpm_meta import pfpm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [FB-1:0]           i_raddr,
    output logic [PAGE_ID_BITS-1:0] o_tag,
    output logic [PIN_BITS-1:0]     o_pins,
    output logic                    o_valid,
    output logic                    o_dirty,
    input  logic                    i_we,
    input  logic [FB-1:0]           i_waddr,
    input  logic [PAGE_ID_BITS-1:0] i_tag,
    input  logic [PIN_BITS-1:0]     i_pins,
    input  logic                    i_valid,
    input  logic                    i_dirty
);
    logic [PAGE_ID_BITS+PIN_BITS:0] mem [FRAMES];
    logic [FRAMES-1:0] r_valid;
    logic [PAGE_ID_BITS+PIN_BITS:0] r_q;
    logic r_v;

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= {i_tag, i_pins, i_dirty};
        r_q <= mem[i_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= '0;
        else if (i_we) r_valid[i_waddr] <= i_valid;
        r_v <= r_valid[i_raddr] && !(!i_rst_n);
    end
    assign o_valid = r_v;
    assign o_tag = r_q[PAGE_ID_BITS+PIN_BITS:PIN_BITS+1];
    assign o_pins = r_v ? r_q[PIN_BITS:1] : '0;
    assign o_dirty = r_v ? r_q[0] : 1'b0;
endmodule
